>>> rtl/fnd_pkg.sv
// ----------------------------------------------------------------------------
// fnd_pkg: fractional-N divider calculator package
// Widths, constants, pipeline stage record and the divider chunk function.
// ----------------------------------------------------------------------------
`default_nettype none

package fnd_pkg;

    localparam int FREQ_W         = 20;
    localparam int PD_W           = 14;
    localparam int D_W            = PD_W + 2;
    localparam int MAX_LO_DIV_LOG = 5;
    localparam int EXT_W          = FREQ_W + MAX_LO_DIV_LOG;
    localparam int FRAC_HI_W      = 16;
    localparam int FRAC_LO_W      = 8;
    localparam int FRAC_W         = FRAC_HI_W + FRAC_LO_W;
    localparam int ACC_W          = FREQ_W + FRAC_W;
    localparam int N_W            = 16;
    localparam int STEP_BITS      = 4;
    localparam int DIV_STAGES     = ACC_W / STEP_BITS;

    localparam logic [PD_W-1:0]   PD_RESET      = PD_W'(1000);
    localparam logic [EXT_W-1:0]  LO_NUMERATOR  = EXT_W'(540000);
    localparam logic [FREQ_W-1:0] PRESC_THRESH  = FREQ_W'(320000);

    localparam logic [1:0] PRESC_DIV2 = 2'd1;
    localparam logic [1:0] PRESC_DIV4 = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    typedef struct packed {
        logic [2:0]        e;
        logic [1:0]        code;
        logic              zero;
        logic [FREQ_W-1:0] vco;
        logic [D_W-1:0]    d;
        logic [D_W-1:0]    rem;
        logic [ACC_W-1:0]  acc;   // dividend bits shift out the top, quotient in
    } stage_t;

    // Restoring division, STEP_BITS quotient bits.
    function automatic stage_t div_chunk(stage_t s);
        stage_t       r;
        logic [D_W:0] trial;
        r = s;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {r.rem, r.acc[ACC_W-1]};
            r.acc = {r.acc[ACC_W-2:0], 1'b0};
            if (trial >= {1'b0, r.d}) begin
                trial    = trial - {1'b0, r.d};
                r.acc[0] = 1'b1;
            end
            r.rem = trial[D_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/frac_n_divider_calculator_core.sv
// ----------------------------------------------------------------------------
// frac_n_divider_calculator_core: fractional-N PLL divider calculator
// Pipelined calculation of LO divider, prescaler and N.F divider ratio.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, target_freq) takes one tuning request
//   per transfer, frequency in 10 kHz units. Output channel
//   (out_valid/out_ready) delivers one result per request, in order.
//   cfg_wr_en/cfg_wr_data write pd_freq (phase detector frequency) at any
//   enabled clock edge; write it only while the pipeline is empty.
//   Pipeline: the prep register (exponent, VCO, prescaler, divisor) loads
//   at the input transfer edge; eleven stages of a 44-bit restoring
//   divider follow, four quotient bits each.
//   Throughput: one transfer per cycle while out_ready is held high.
//   Stall: each stage holds while the next is full and stalled; ready
//   ripples back, so bubbles are squeezed out and the input keeps
//   accepting until every stage is full.
//   Reset (rst_n low, async): pipeline empties, pd_freq returns to 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module frac_n_divider_calculator_core
    import fnd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [PD_W-1:0]   cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [FREQ_W-1:0] target_freq,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             lo_div_log,
    output logic [1:0]             presc_code,
    output logic [N_W-1:0]         n_integer,
    output logic [FRAC_HI_W-1:0]   frac_high,
    output logic [FRAC_LO_W-1:0]   frac_low,
    output logic [FREQ_W-1:0]      vco_freq,
    output logic [1:0]             status
);

    localparam int LAST = DIV_STAGES;

    logic [PD_W-1:0] pd_freq_reg;

    stage_t          stg_reg  [0:LAST];
    stage_t          prep_next;
    stage_t          stg_next [1:LAST];
    logic [LAST:0]   vld_reg;
    logic [LAST+1:0] rdy;

    // configuration register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pd_freq_reg <= PD_RESET;
        end
        else if (cfg_wr_en) begin
            pd_freq_reg <= cfg_wr_data;
        end
    end

    // prep stage: exponent, VCO, prescaler, divisor
    always_comb begin
        logic [PD_W-1:0]  pd;
        logic [EXT_W-1:0] ext;
        logic [2:0]       e;
        logic [FREQ_W-1:0] vco;
        pd  = (pd_freq_reg == '0) ? PD_W'(1) : pd_freq_reg;
        ext = EXT_W'(target_freq);
        e   = '0;
        // freq << k <= 540000 is monotone in k, last hit wins
        for (int k = 1; k <= MAX_LO_DIV_LOG; k++) begin
            if ((ext << k) <= LO_NUMERATOR) begin
                e = 3'(k);
            end
        end
        vco = FREQ_W'(ext << e);
        prep_next.e    = e;
        prep_next.zero = (target_freq == '0);
        prep_next.vco  = vco;
        if (vco > PRESC_THRESH) begin
            prep_next.code = PRESC_DIV4;
            prep_next.d    = {pd, 2'b00};
        end
        else begin
            prep_next.code = PRESC_DIV2;
            prep_next.d    = {1'b0, pd, 1'b0};
        end
        prep_next.rem = '0;
        prep_next.acc = {vco, {FRAC_W{1'b0}}};
    end

    // divider stages
    always_comb begin
        for (int k = 1; k <= LAST; k++) begin
            stg_next[k] = div_chunk(stg_reg[k-1]);
        end
    end

    // ready ripples back from the output; an empty stage always takes data
    always_comb begin
        rdy[LAST+1] = out_ready;
        for (int k = LAST; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (rdy[0] && in_valid) begin
            stg_reg[0] <= prep_next;
        end
        for (int k = 1; k <= LAST; k++) begin
            if (rdy[k] && vld_reg[k-1]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    // output formatting
    logic [FREQ_W-1:0] n_full;
    logic              n_sat;

    assign n_full = stg_reg[LAST].acc[ACC_W-1 -: FREQ_W];
    assign n_sat  = (n_full[FREQ_W-1:N_W] != '0);

    assign out_valid = vld_reg[LAST];

    always_comb begin
        if (stg_reg[LAST].zero) begin
            lo_div_log = '0;
            presc_code = PRESC_DIV2;
            n_integer  = '0;
            frac_high  = '0;
            frac_low   = '0;
            vco_freq   = '0;
            status     = STATUS_ZERO;
        end
        else begin
            lo_div_log = stg_reg[LAST].e;
            presc_code = stg_reg[LAST].code;
            n_integer  = n_sat ? {N_W{1'b1}} : n_full[N_W-1:0];
            frac_high  = stg_reg[LAST].acc[FRAC_W-1 -: FRAC_HI_W];
            frac_low   = stg_reg[LAST].acc[FRAC_LO_W-1:0];
            vco_freq   = stg_reg[LAST].vco;
            status     = n_sat ? STATUS_SAT : STATUS_OK;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: fractional-N divider calculator testbench
// Sends tuning requests under random sender gaps and receiver stalls, and
// checks every result against an internal divider-ratio predictor. It steps
// pd_freq through its extremes between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import fnd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT   = 11;          // transfer in to out_valid
    localparam int SETTLE     = PIPE_LAT + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS = 1300;

    // One expected tuning result
    typedef struct {
        logic [2:0]           e;
        logic [1:0]           code;
        logic [N_W-1:0]       n;
        logic [FRAC_HI_W-1:0] fhi;
        logic [FRAC_LO_W-1:0] flo;
        logic [FREQ_W-1:0]    vco;
        logic [1:0]           st;
    } tuning_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [PD_W-1:0]        cfg_wr_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [FREQ_W-1:0]      target_freq = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [2:0]             lo_div_log;
    logic [1:0]             presc_code;
    logic [N_W-1:0]         n_integer;
    logic [FRAC_HI_W-1:0]   frac_high;
    logic [FRAC_LO_W-1:0]   frac_low;
    logic [FREQ_W-1:0]      vco_freq;
    logic [1:0]             status;

    tuning_t         pending_tunings[$];
    logic [PD_W-1:0] pd_shadow = PD_RESET;   // our copy of the register
    int              errors = 0;
    int              cycles = 0;

    frac_n_divider_calculator_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .target_freq (target_freq),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .lo_div_log  (lo_div_log),
        .presc_code  (presc_code),
        .n_integer   (n_integer),
        .frac_high   (frac_high),
        .frac_low    (frac_low),
        .vco_freq    (vco_freq),
        .status      (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Divider settings for one target at the current pd_freq
    function automatic tuning_t predict_tuning(logic [FREQ_W-1:0] freq, logic [PD_W-1:0] pd_reg);
        tuning_t     t;
        longint unsigned q, pd, d, vco, n, rem, hi, rem2;
        int          ex;
        if (freq == '0) begin
            t.e = '0; t.code = PRESC_DIV2; t.n = '0; t.fhi = '0; t.flo = '0;
            t.vco = '0; t.st = STATUS_ZERO;
            return t;
        end
        pd = (pd_reg == '0) ? 64'd1 : 64'(pd_reg);   // zero register acts as 1
        q  = 64'd540000 / 64'(freq);
        ex = 0;
        while (ex < MAX_LO_DIV_LOG && (q >> (ex + 1)) != 0)
            ex++;
        vco = 64'(freq) << ex;
        if (vco > 64'd320000) begin
            d = pd * 4; t.code = PRESC_DIV4;
        end
        else begin
            d = pd * 2; t.code = PRESC_DIV2;
        end
        n    = vco / d;
        rem  = vco - n * d;
        hi   = (rem << 16) / d;
        rem2 = (rem << 16) - hi * d;
        t.flo = FRAC_LO_W'((rem2 << 8) / d);
        t.fhi = FRAC_HI_W'(hi);
        t.e   = 3'(ex);
        t.vco = FREQ_W'(vco);
        if (n > 64'd65535) begin
            t.n = '1; t.st = STATUS_SAT;
        end
        else begin
            t.n = N_W'(n); t.st = STATUS_OK;
        end
        return t;
    endfunction

    // ---- sender side -------------------------------------------------------
    // Holds valid until the transfer; caller decides whether to idle after.
    task automatic send_request(logic [FREQ_W-1:0] freq);
        in_valid    <= 1'b1;
        target_freq <= freq;
        do @(posedge clk); while (!in_ready);
        pending_tunings.push_back(predict_tuning(freq, pd_shadow));
    endtask

    task automatic idle_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Wait for every result, then let the pipeline settle.
    task automatic drain();
        idle_sender(1);
        while (pending_tunings.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_pd(logic [PD_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        pd_shadow    = v;
    endtask

    // Bursts of back-to-back transfers separated by random gaps
    int burst_left = 0;
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 30);
        if ($urandom_range(0, 3) != 0)
            idle_sender($urandom_range(1, 12));
    endtask

    function automatic logic [FREQ_W-1:0] rand_target();
        case ($urandom_range(0, 7))
            0:       return FREQ_W'($urandom_range(1, 600));         // deep divide
            1:       return FREQ_W'($urandom_range(16000, 17000));   // cap boundary
            2:       return FREQ_W'($urandom_range(319000, 321000)); // prescaler edge
            3:       return FREQ_W'($urandom_range(530000, 550000)); // around LO_NUMERATOR
            4:       return ($urandom_range(0, 3) == 0) ? '0
                                                        : FREQ_W'($urandom_range(1, 270000));
            default: return FREQ_W'($urandom());
        endcase
    endfunction

    // ---- receiver side -----------------------------------------------------
    // Stall pattern periodically draws a random mode: free flow, coin toss,
    // or long stretches held off.
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if (cycles % 128 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // ---- result check ------------------------------------------------------
    always @(posedge clk)
    begin
        tuning_t exp_t;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready) begin
            if (pending_tunings.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else begin
                exp_t = pending_tunings.pop_front();
                if (lo_div_log !== exp_t.e) begin
                    $error("lo_div_log exp %0d got %0d", exp_t.e, lo_div_log); errors++;
                end
                if (presc_code !== exp_t.code) begin
                    $error("presc_code exp %0d got %0d", exp_t.code, presc_code); errors++;
                end
                if (n_integer !== exp_t.n) begin
                    $error("n_integer exp %0d got %0d", exp_t.n, n_integer); errors++;
                end
                if (frac_high !== exp_t.fhi) begin
                    $error("frac_high exp %0d got %0d", exp_t.fhi, frac_high); errors++;
                end
                if (frac_low !== exp_t.flo) begin
                    $error("frac_low exp %0d got %0d", exp_t.flo, frac_low); errors++;
                end
                if (vco_freq !== exp_t.vco) begin
                    $error("vco_freq exp %0d got %0d", exp_t.vco, vco_freq); errors++;
                end
                if (status !== exp_t.st) begin
                    $error("status exp %0d got %0d", exp_t.st, status); errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ---- tests -------------------------------------------------------------
    // Field extremes and boundary cases, at reset pd_freq
    task automatic test_directed();
        logic [FREQ_W-1:0] pts [0:16] = '{20'd0, 20'd1, 20'd2, 20'd16874, 20'd16875,
                                          20'd16876, 20'd33750, 20'd270000,
                                          20'd320000, 20'd320001, 20'd540000,
                                          20'd540001, 20'd1048575, 20'hAAAAA,
                                          20'h55555, 20'd160000, 20'd160001};
        foreach (pts[i]) send_request(pts[i]);
        idle_sender(3);
        send_request(20'd1000);
    endtask

    // Saturation needs a tiny divisor
    task automatic test_small_pd();
        write_pd(14'd1);
        send_request(20'd1048575);
        send_request(20'd320000);
        send_request(20'd16875);
        send_request(20'd3);
        write_pd(14'd0);                          // zero acts as 1
        send_request(20'd540000);
        send_request(20'd1);
    endtask

    task automatic test_random_phase(int n);
        repeat (n) begin
            send_request(rand_target());
            pace();
        end
    endtask

    task automatic test_random();
        logic [PD_W-1:0] pds [0:4] = '{14'd16383, 14'd1, 14'd0, 14'd1000, 14'd3};
        foreach (pds[i]) begin
            write_pd(pds[i]);
            test_random_phase(RAND_ITEMS / 10);
        end
        repeat (5) begin
            write_pd(PD_W'($urandom()));
            test_random_phase(RAND_ITEMS / 10);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_small_pd();
        test_random();
        drain();
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/fnd_pkg.sv
rtl/frac_n_divider_calculator_core.sv
tb/tb_top.sv
